/* rtl/acir_pkg.sv */
// Word types, timing constants and protocol codes for the IR remote frame encoder.
package acir_pkg;

    localparam int DUR_W = 15;
    localparam int POS_W = 8;

    typedef struct packed {
        logic       kind;
        logic [2:0] mode;
        logic [7:0] temp_c;
        logic [1:0] fan;
        logic       power;
    } in_word_t;

    typedef struct packed {
        logic [DUR_W-1:0] duration_us;
        logic             is_mark;
        logic             last;
    } out_word_t;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_FETCH = 1'b1;

    localparam logic PROTO_SHORT = 1'b0;
    localparam logic PROTO_LONG  = 1'b1;

    localparam logic [DUR_W-1:0] P0_HDR_MARK   = 15'd4480;
    localparam logic [DUR_W-1:0] P0_HDR_SPACE  = 15'd4480;
    localparam logic [DUR_W-1:0] P0_BIT_MARK   = 15'd560;
    localparam logic [DUR_W-1:0] P0_ONE_SPACE  = 15'd1680;
    localparam logic [DUR_W-1:0] P0_ZERO_SPACE = 15'd560;
    localparam logic [DUR_W-1:0] P0_GAP        = 15'd5600;
    localparam logic [POS_W-1:0] P0_FOOT_POS   = 8'd194;
    localparam logic [POS_W-1:0] P0_LAST_POS   = 8'd195;
    localparam logic [POS_W-1:0] P0_HALF_LEN   = 8'd96;

    localparam logic [DUR_W-1:0] P1_HDR_MARK   = 15'd9000;
    localparam logic [DUR_W-1:0] P1_HDR_SPACE  = 15'd4500;
    localparam logic [DUR_W-1:0] P1_BIT_MARK   = 15'd620;
    localparam logic [DUR_W-1:0] P1_ONE_SPACE  = 15'd1600;
    localparam logic [DUR_W-1:0] P1_ZERO_SPACE = 15'd540;
    localparam logic [DUR_W-1:0] P1_GAP        = 15'd19980;
    localparam logic [POS_W-1:0] P1_BLOCK_LEN  = 8'd72;
    localparam logic [POS_W-1:0] P1_END_Q      = 8'd144;
    localparam logic [6:0]       P1_FOOT_MARK  = 7'd70;
    localparam logic [6:0]       P1_FOOT_GAP   = 7'd71;
    localparam logic [6:0]       P1_DATA_LEN   = 7'd64;

    function automatic logic [7:0] rev8(input logic [7:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[i] = v[7-i];
        end
        return r;
    endfunction

endpackage

/* rtl/ac_ir_frame_encoder.sv */
// Top level of the IR remote frame encoder: frame builder and duration sequencer.
//
// The s_ channel takes one word per accepted handshake. A load word (kind 0)
// builds a new frame from mode, temperature, fan and power, using the protocol
// held in the configuration register, and restarts the sequence; it gives no
// result. Each fetch word (kind 1) gives the next mark or space duration on the
// m_ channel, with last set on the final gap. A fetch while no frame is pending
// is taken and gives nothing.
// m_valid rises in the cycle after an accepted fetch. Throughput is one word per
// cycle: a load updates the frame bits and position, and a fetch the position
// and result register, each at a single edge; s_ready stays high while the
// result register is empty or is being emptied. When the receiver stalls, the
// result holds and s_ready drops until it is taken.
// A short-protocol frame is 196 entries, a long-protocol frame 146 entries.
// Reset clears the configuration register to the short protocol, drops any
// pending frame and empties the result register.
module ac_ir_frame_encoder
    import acir_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      cfg_wr_en,
    input  logic      cfg_wr_data,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);

    logic             protocol_select_reg;
    logic [63:0]      frame_reg, frame_next;
    logic             proto_reg;
    logic [POS_W-1:0] pos_reg;
    logic             active_reg;
    logic             m_valid_reg;
    out_word_t        m_data_reg, entry;
    logic             accept, is_load, emit;

    function automatic logic [63:0] build_short(input in_word_t w);
        logic [7:0] t, b0, b3, b4, sum;
        t   = (w.temp_c < 8'd17) ? 8'd17 : ((w.temp_c > 8'd30) ? 8'd30 : w.temp_c);
        b3  = {t[3:0] - 4'd1, 4'h0};
        b4  = {w.mode, w.fan, 2'b00, w.power};
        sum = rev8(8'h80) + rev8(8'hC0) + rev8(b3) + rev8(b4);
        b0  = rev8(8'd0 - sum);
        return {16'h0000, 8'h34, b4, b3, 8'hC0, 8'h80, b0};
    endfunction

    function automatic logic [63:0] build_long(input in_word_t w);
        logic [7:0] t, b0, b1, x;
        logic [3:0] c;
        t  = (w.temp_c < 8'd16) ? 8'd16 : ((w.temp_c > 8'd30) ? 8'd30 : w.temp_c);
        b0 = {w.fan, 1'b1, 1'b0, w.power, w.mode};
        b1 = {4'h0, t[3:0]};
        x  = b0 ^ b1 ^ 8'h10 ^ 8'h05 ^ 8'h10 ^ 8'h40;
        c  = x[7:4] ^ x[3:0];
        return {c, 4'h0, 8'h00, 8'h40, 8'h10, 8'h05, 8'h10, b1, b0};
    endfunction

    function automatic out_word_t entry_short(input logic [63:0] f,
                                              input logic [POS_W-1:0] p);
        out_word_t  o;
        logic [POS_W-1:0] q;
        logic       inv, b;
        logic [6:0] r;
        q   = p - 8'd2;
        inv = (q >= P0_HALF_LEN);
        r   = inv ? 7'(q - P0_HALF_LEN) : q[6:0];
        b   = f[r[6:1]] ^ inv;
        o.last = 1'b0;
        if (p == 8'd0) begin
            o.duration_us = P0_HDR_MARK;
            o.is_mark     = 1'b1;
        end else if (p == 8'd1) begin
            o.duration_us = P0_HDR_SPACE;
            o.is_mark     = 1'b0;
        end else if (p == P0_FOOT_POS) begin
            o.duration_us = P0_BIT_MARK;
            o.is_mark     = 1'b1;
        end else if (p >= P0_LAST_POS) begin
            o.duration_us = P0_GAP;
            o.is_mark     = 1'b0;
            o.last        = 1'b1;
        end else if (!r[0]) begin
            o.duration_us = P0_BIT_MARK;
            o.is_mark     = 1'b1;
        end else begin
            o.duration_us = b ? P0_ONE_SPACE : P0_ZERO_SPACE;
            o.is_mark     = 1'b0;
        end
        return o;
    endfunction

    function automatic out_word_t entry_long(input logic [63:0] f,
                                             input logic [POS_W-1:0] p);
        out_word_t  o;
        logic [POS_W-1:0] q;
        logic       blk, b;
        logic [6:0] r;
        q   = p - 8'd2;
        blk = (q >= P1_BLOCK_LEN);
        r   = blk ? 7'(q - P1_BLOCK_LEN) : q[6:0];
        b   = (r < P1_DATA_LEN) ? f[{blk, r[5:1]}] : (r[2:1] == 2'd1);
        o.last = 1'b0;
        if (p == 8'd0) begin
            o.duration_us = P1_HDR_MARK;
            o.is_mark     = 1'b1;
        end else if (p == 8'd1) begin
            o.duration_us = P1_HDR_SPACE;
            o.is_mark     = 1'b0;
        end else if (q >= P1_END_Q) begin
            o.duration_us = P1_GAP;
            o.is_mark     = 1'b0;
            o.last        = 1'b1;
        end else if (r == P1_FOOT_MARK) begin
            o.duration_us = P1_BIT_MARK;
            o.is_mark     = 1'b1;
        end else if (r == P1_FOOT_GAP) begin
            o.duration_us = P1_GAP;
            o.is_mark     = 1'b0;
            o.last        = blk;
        end else if (!r[0]) begin
            o.duration_us = P1_BIT_MARK;
            o.is_mark     = 1'b1;
        end else begin
            o.duration_us = b ? P1_ONE_SPACE : P1_ZERO_SPACE;
            o.is_mark     = 1'b0;
        end
        return o;
    endfunction

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign is_load = (s_data.kind == KIND_LOAD);
    assign emit    = accept && !is_load && active_reg;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        frame_next = (protocol_select_reg == PROTO_LONG) ? build_long(s_data)
                                                         : build_short(s_data);
        entry = (proto_reg == PROTO_LONG) ? entry_long(frame_reg, pos_reg)
                                          : entry_short(frame_reg, pos_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            protocol_select_reg <= PROTO_SHORT;
            frame_reg           <= '0;
            proto_reg           <= PROTO_SHORT;
            pos_reg             <= '0;
            active_reg          <= 1'b0;
            m_valid_reg         <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                protocol_select_reg <= cfg_wr_data;
            end
            if (accept && is_load) begin
                frame_reg  <= frame_next;
                proto_reg  <= protocol_select_reg;
                pos_reg    <= '0;
                active_reg <= 1'b1;
            end else if (emit) begin
                if (entry.last) begin
                    active_reg <= 1'b0;
                end else begin
                    pos_reg <= pos_reg + 8'd1;
                end
            end
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_data_reg <= entry;
        end
    end

endmodule
